>>> hw/rtl/tpp_pkg.sv
package tpp_pkg;

  // default widths
  localparam int POS_WIDTH_DEF = 32;
  localparam int SQRT_FRAC_DEF = 16;

  // iteration counts of the shared units
  localparam int DIV_STEPS   = 64;
  localparam int ISQRT_STEPS = 32;

  // motion phases
  localparam logic [2:0] PH_PRE    = 3'd0;
  localparam logic [2:0] PH_ACCEL  = 3'd1;
  localparam logic [2:0] PH_CRUISE = 3'd2;
  localparam logic [2:0] PH_DECEL  = 3'd3;
  localparam logic [2:0] PH_END    = 3'd4;

  // item kinds
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // register indexes
  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_ACCEL     = 2'd1;
  localparam logic [1:0] REG_DECEL     = 2'd2;

endpackage

>>> hw/rtl/trapezoid_position_profile.sv
// Trapezoidal position profile generator. A start item (tuser = 0) plans a move of a signed
// distance from a start position, beginning at a start period; it gives no result. A tick
// item (tuser = 1) carries an absolute period number and gives one result: the commanded
// position and, on tlast, a finished flag. Planning runs on one shared restoring divider,
// one digit-by-digit square root unit (with SQRT_FRAC_BITS extra fraction bits for the
// deceleration root) and one registered 34x32 multiplier, all sequenced by a small state
// machine. After it is taken, a start keeps the block busy while it plans, along a path
// that depends on the branch taken (not at all when the move ends at once). A tick keeps
// it busy while it walks the phases, plus any wait for the output register to free up.
// The block takes one item at a time; a result waiting in the output register does not block
// the next item. Config writes are always ready and are expected only while the block is idle.
module trapezoid_position_profile #(
  parameter int POS_WIDTH      = tpp_pkg::POS_WIDTH_DEF,
  parameter int SQRT_FRAC_BITS = tpp_pkg::SQRT_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // config write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [95:0] s_tdata,   // distance, start_position, period
  input  logic        s_tuser,   // command
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // position_order
  output logic        m_tlast    // finished
);

  localparam int SQ_STEPS = tpp_pkg::ISQRT_STEPS + SQRT_FRAC_BITS;
  localparam int STEP_MAX = (SQ_STEPS > tpp_pkg::DIV_STEPS) ? SQ_STEPS : tpp_pkg::DIV_STEPS;
  localparam int CNT_W    = $clog2(STEP_MAX + 1);

  // sequencer states
  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_WAIT   = 5'd1;
  localparam logic [4:0] ST_T1     = 5'd2;
  localparam logic [4:0] ST_T3     = 5'd3;
  localparam logic [4:0] ST_M1     = 5'd4;
  localparam logic [4:0] ST_M2     = 5'd5;
  localparam logic [4:0] ST_M3     = 5'd6;
  localparam logic [4:0] ST_M4     = 5'd7;
  localparam logic [4:0] ST_M5     = 5'd8;
  localparam logic [4:0] ST_FEAS   = 5'd9;
  localparam logic [4:0] ST_I1     = 5'd10;
  localparam logic [4:0] ST_I2     = 5'd11;
  localparam logic [4:0] ST_I3     = 5'd12;
  localparam logic [4:0] ST_I4     = 5'd13;
  localparam logic [4:0] ST_I5     = 5'd14;
  localparam logic [4:0] ST_I6     = 5'd15;
  localparam logic [4:0] ST_I7     = 5'd16;
  localparam logic [4:0] ST_I8     = 5'd17;
  localparam logic [4:0] ST_I9     = 5'd18;
  localparam logic [4:0] ST_I10    = 5'd19;
  localparam logic [4:0] ST_F1     = 5'd20;
  localparam logic [4:0] ST_F2     = 5'd21;
  localparam logic [4:0] ST_F3     = 5'd22;
  localparam logic [4:0] ST_F4     = 5'd23;
  localparam logic [4:0] ST_F5     = 5'd24;
  localparam logic [4:0] ST_F6     = 5'd25;
  localparam logic [4:0] ST_TK     = 5'd26;
  localparam logic [4:0] ST_TK_ACC = 5'd27;
  localparam logic [4:0] ST_TK_DEC = 5'd28;
  localparam logic [4:0] ST_OUT    = 5'd29;

  logic [4:0] state;
  logic [4:0] ret_state;

  // config registers
  logic [23:0] max_speed;
  logic [15:0] acceleration;
  logic [15:0] deceleration;

  // move state
  logic [2:0]                  phase;
  logic [31:0]                 phase_start;
  logic [31:0]                 accel_time;
  logic [31:0]                 cruise_time;
  logic [31:0]                 decel_time;
  logic                        neg;        // sign of the move
  logic [15:0]                 acc_mag;
  logic [15:0]                 dec_mag;
  logic [33:0]                 spd_mag;
  logic signed [POS_WIDTH-1:0] start_order;
  logic signed [POS_WIDTH-1:0] previous_order;
  logic signed [POS_WIDTH-1:0] target_position;

  // planning scratch
  logic [31:0] dist_mag;
  logic [63:0] acc_a;        // a*t1^2
  logic [63:0] acc_d;        // d*t3^2
  logic [63:0] tmp;
  logic [31:0] tick_period;
  logic signed [POS_WIDTH-1:0] order;
  logic        fin;

  // shared units
  logic [63:0]      prod;
  logic [33:0]      mul_a;
  logic [31:0]      mul_b;
  logic [65:0]      mul_full;
  logic [CNT_W-1:0] cnt;
  logic             unit_sqrt;
  logic [63:0]      div_q;
  logic [33:0]      div_d;
  logic [33:0]      div_r;
  logic [34:0]      div_rs;
  logic             div_ge;
  logic [63:0]      sq_x;
  logic [63:0]      sq_root;
  logic [65:0]      sq_rem;
  logic [65:0]      sq_rn;
  logic [65:0]      sq_trial;
  logic             sq_ge;

  // combinational helpers
  logic [31:0]        rel;
  logic signed [31:0] in_dist;
  logic signed [31:0] in_pos;
  logic signed [63:0] dist_ext;
  logic signed [63:0] pos_ext;
  logic signed [63:0] sum_ext;
  logic               in_zero;
  logic [63:0]        two_m;
  logic [63:0]        feas;
  logic signed [63:0] diff;
  logic signed [63:0] b_val;
  logic [63:0]        half_x;
  logic [63:0]        r_full;
  logic signed [63:0] delta;
  logic [63:0]        vs;
  logic [63:0]        step_mag;
  logic [63:0]        step_signed;
  logic [63:0]        prev_ext;
  logic [63:0]        order_sum;
  logic [63:0]        order_ext;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == ST_IDLE);

  assign in_dist  = s_tdata[31:0];
  assign in_pos   = s_tdata[63:32];
  assign dist_ext = 64'(in_dist);
  assign pos_ext  = 64'(in_pos);
  assign sum_ext  = 64'(in_pos) + dist_ext;
  assign in_zero  = (in_dist == 32'sd0) || (max_speed == 24'd0) ||
                    (acceleration == 16'd0) || (deceleration == 16'd0);

  assign rel = tick_period - phase_start;

  // planning arithmetic
  assign two_m  = {31'd0, dist_mag, 1'b0};
  assign feas   = acc_a + {prod[62:0], 1'b0} - acc_d;
  assign diff   = signed'(64'(dist_mag) - (acc_d >> 1) - (acc_a >> 1));
  assign half_x = prod - (prod >> 1);
  assign b_val  = signed'(64'(dist_mag) - half_x);
  assign r_full = 64'(dist_mag) - prod - (acc_a >> 1);
  assign delta  = signed'(prod - {tmp[62:0], 1'b0});
  assign vs     = 64'(spd_mag) << SQRT_FRAC_BITS;

  // multiplier operand select
  always_comb begin
    mul_a = 34'd0;
    mul_b = 32'd0;
    case (state)
      ST_M1:   begin mul_a = 34'(acc_mag);  mul_b = accel_time; end
      ST_M2:   begin mul_a = prod[33:0];    mul_b = accel_time; end
      ST_M3:   begin mul_a = 34'(dec_mag);  mul_b = decel_time; end
      ST_M4:   begin mul_a = prod[33:0];    mul_b = decel_time; end
      ST_M5:   begin mul_a = spd_mag;       mul_b = decel_time; end
      ST_I1:   begin mul_a = 34'(acc_mag);  mul_b = dist_mag;   end
      ST_I2:   begin mul_a = 34'(dec_mag);  mul_b = 32'(acc_mag) + 32'(dec_mag); end
      ST_I6:   begin mul_a = 34'(dec_mag);  mul_b = decel_time; end
      ST_I7:   begin mul_a = prod[33:0];    mul_b = decel_time; end
      ST_F1:   begin mul_a = div_q[33:0];   mul_b = spd_mag[31:0]; end
      ST_F2:   begin mul_a = 34'(dec_mag);  mul_b = r_full[31:0]; end
      ST_F3:   begin mul_a = spd_mag;       mul_b = spd_mag[31:0]; end
      ST_TK: begin
        if (phase == tpp_pkg::PH_DECEL) begin
          mul_a = 34'(dec_mag);
        end else begin
          mul_a = 34'(acc_mag);
        end
        mul_b = rel;
      end
      default: begin mul_a = 34'd0; mul_b = 32'd0; end
    endcase
  end

  assign mul_full = 66'(mul_a) * 66'(mul_b);

  // divider and square root steps
  assign div_rs   = {div_r, div_q[63]};
  assign div_ge   = (div_rs >= {1'b0, div_d});
  assign sq_rn    = {sq_rem[63:0], sq_x[63:62]};
  assign sq_trial = {sq_root, 2'b01};
  assign sq_ge    = (sq_rn >= sq_trial);

  // position step magnitude per phase, then signed and added to the last order
  always_comb begin
    case (state)
      ST_TK_ACC: step_mag = prod + 64'(acc_mag >> 1);
      ST_TK_DEC: step_mag = 64'(spd_mag) - prod - 64'(dec_mag >> 1);
      default:   step_mag = 64'(spd_mag);
    endcase
  end

  assign step_signed = neg ? (64'd0 - step_mag) : step_mag;
  assign prev_ext    = 64'(previous_order);
  assign order_sum   = prev_ext + step_signed;
  assign order_ext   = 64'(order);

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      ret_state       <= ST_IDLE;
      max_speed       <= 24'd0;
      acceleration    <= 16'd0;
      deceleration    <= 16'd0;
      phase           <= tpp_pkg::PH_END;
      phase_start     <= 32'd0;
      accel_time      <= 32'd0;
      cruise_time     <= 32'd0;
      decel_time      <= 32'd0;
      neg             <= 1'b0;
      acc_mag         <= 16'd0;
      dec_mag         <= 16'd0;
      spd_mag         <= 34'd0;
      start_order     <= '0;
      previous_order  <= '0;
      target_position <= '0;
      cnt             <= '0;
      unit_sqrt       <= 1'b0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          tpp_pkg::REG_MAX_SPEED: max_speed    <= cfg_data;
          tpp_pkg::REG_ACCEL:     acceleration <= cfg_data[15:0];
          tpp_pkg::REG_DECEL:     deceleration <= cfg_data[15:0];
          default: ;
        endcase
      end

      // the output step reloads the register itself
      if (m_tvalid && m_tready && (state != ST_OUT)) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            tick_period <= s_tdata[95:64];
            if (s_tuser == tpp_pkg::CMD_TICK) begin
              state <= ST_TK;
            end else begin
              phase_start     <= s_tdata[95:64];
              start_order     <= pos_ext[POS_WIDTH-1:0];
              previous_order  <= pos_ext[POS_WIDTH-1:0];
              target_position <= sum_ext[POS_WIDTH-1:0];
              neg             <= in_dist[31];
              dist_mag        <= in_dist[31] ? (32'd0 - in_dist) : in_dist;
              if (in_zero) begin
                accel_time  <= 32'd0;
                cruise_time <= 32'd0;
                decel_time  <= 32'd0;
                acc_mag     <= 16'd0;
                dec_mag     <= 16'd0;
                spd_mag     <= 34'd0;
                phase       <= tpp_pkg::PH_END;
              end else begin
                acc_mag     <= acceleration;
                dec_mag     <= deceleration;
                spd_mag     <= 34'(max_speed);
                cruise_time <= 32'd0;
                phase       <= tpp_pkg::PH_PRE;
                state       <= ST_T1;
              end
            end
          end
        end

        // shared divider / square root iterations
        ST_WAIT: begin
          if (unit_sqrt) begin
            sq_rem  <= sq_ge ? (sq_rn - sq_trial) : sq_rn;
            sq_root <= {sq_root[62:0], sq_ge};
            sq_x    <= {sq_x[61:0], 2'b00};
          end else begin
            div_r <= div_ge ? 34'(div_rs - {1'b0, div_d}) : div_rs[33:0];
            div_q <= {div_q[62:0], div_ge};
          end
          cnt <= cnt - 1'b1;
          if (cnt == CNT_W'(1)) begin
            state <= ret_state;
          end
        end

        // t1 = v / a
        ST_T1: begin
          div_q     <= 64'(spd_mag);
          div_d     <= 34'(acc_mag);
          div_r     <= 34'd0;
          unit_sqrt <= 1'b0;
          cnt       <= CNT_W'(tpp_pkg::DIV_STEPS);
          ret_state <= ST_T3;
          state     <= ST_WAIT;
        end

        // t3 = v / d
        ST_T3: begin
          accel_time <= div_q[31:0];
          div_q      <= 64'(spd_mag);
          div_d      <= 34'(dec_mag);
          div_r      <= 34'd0;
          cnt        <= CNT_W'(tpp_pkg::DIV_STEPS);
          ret_state  <= ST_M1;
          state      <= ST_WAIT;
        end

        ST_M1: begin
          decel_time <= div_q[31:0];
          state      <= ST_M2;
        end
        ST_M2: state <= ST_M3;
        ST_M3: begin
          acc_a <= prod;
          state <= ST_M4;
        end
        ST_M4: state <= ST_M5;
        ST_M5: begin
          acc_d <= prod;
          state <= ST_FEAS;
        end

        // feasibility: a*t1^2 + 2*v*t3 - d*t3^2 against 2*m
        ST_FEAS: begin
          if (feas > two_m) begin
            state <= ST_I1;
          end else if (diff > 64'sd0) begin
            div_q     <= diff;
            div_d     <= spd_mag;
            div_r     <= 34'd0;
            unit_sqrt <= 1'b0;
            cnt       <= CNT_W'(tpp_pkg::DIV_STEPS);
            ret_state <= ST_F1;
            state     <= ST_WAIT;
          end else begin
            div_q <= 64'd0;
            state <= ST_F1;
          end
        end

        // speed not reachable: triangle profile
        ST_I1: state <= ST_I2;
        ST_I2: begin
          tmp   <= {prod[60:0], 3'b000};   // 4 * 2*a*m
          state <= ST_I3;
        end
        ST_I3: begin
          div_q     <= tmp;
          div_d     <= prod[33:0];
          div_r     <= 34'd0;
          unit_sqrt <= 1'b0;
          cnt       <= CNT_W'(tpp_pkg::DIV_STEPS);
          ret_state <= ST_I4;
          state     <= ST_WAIT;
        end
        ST_I4: begin
          sq_x      <= div_q;
          sq_root   <= 64'd0;
          sq_rem    <= 66'd0;
          unit_sqrt <= 1'b1;
          cnt       <= CNT_W'(tpp_pkg::ISQRT_STEPS);
          ret_state <= ST_I5;
          state     <= ST_WAIT;
        end
        ST_I5: begin
          decel_time <= 32'((sq_root + 64'd1) >> 1);
          state      <= ST_I6;
        end
        ST_I6: state <= ST_I7;
        ST_I7: begin
          spd_mag <= prod[33:0];
          state   <= ST_I8;
        end
        ST_I8: begin
          // remaining distance after decel, clamped at zero
          if (b_val > 64'sd0) begin
            div_q     <= {b_val[62:0], 1'b0};
            div_d     <= 34'(acc_mag);
            div_r     <= 34'd0;
            unit_sqrt <= 1'b0;
            cnt       <= CNT_W'(tpp_pkg::DIV_STEPS);
            ret_state <= ST_I9;
            state     <= ST_WAIT;
          end else begin
            div_q <= 64'd0;
            state <= ST_I9;
          end
        end
        ST_I9: begin
          sq_x      <= {div_q[61:0], 2'b00};
          sq_root   <= 64'd0;
          sq_rem    <= 66'd0;
          unit_sqrt <= 1'b1;
          cnt       <= CNT_W'(tpp_pkg::ISQRT_STEPS);
          ret_state <= ST_I10;
          state     <= ST_WAIT;
        end
        ST_I10: begin
          accel_time  <= 32'((sq_root + 64'd1) >> 1);
          cruise_time <= 32'd0;
          state       <= ST_IDLE;
        end

        // full trapezoid
        ST_F1: begin
          cruise_time <= div_q[31:0];
          state       <= ST_F2;
        end
        ST_F2: state <= ST_F3;
        ST_F3: begin
          tmp   <= prod;                   // d*r
          state <= ST_F4;
        end
        ST_F4: begin
          if (delta > 64'sd0) begin
            sq_x      <= delta;
            sq_root   <= 64'd0;
            sq_rem    <= 66'd0;
            unit_sqrt <= 1'b1;
            cnt       <= CNT_W'(SQ_STEPS);
            ret_state <= ST_F5;
            state     <= ST_WAIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_F5: begin
          if (sq_root > vs) begin
            decel_time <= 32'd0;
            state      <= ST_IDLE;
          end else begin
            div_q     <= (vs - sq_root) >> SQRT_FRAC_BITS;
            div_d     <= 34'(dec_mag);
            div_r     <= 34'd0;
            unit_sqrt <= 1'b0;
            cnt       <= CNT_W'(tpp_pkg::DIV_STEPS);
            ret_state <= ST_F6;
            state     <= ST_WAIT;
          end
        end
        ST_F6: begin
          decel_time <= div_q[31:0];
          state      <= ST_IDLE;
        end

        // tick: walk phases, one per cycle
        ST_TK: begin
          case (phase)
            tpp_pkg::PH_PRE: begin
              if (tick_period >= phase_start) begin
                phase <= tpp_pkg::PH_ACCEL;
              end else begin
                order <= start_order;
                fin   <= 1'b0;
                state <= ST_OUT;
              end
            end
            tpp_pkg::PH_ACCEL: begin
              if (rel >= accel_time) begin
                phase_start <= phase_start + accel_time;
                phase       <= tpp_pkg::PH_CRUISE;
              end else begin
                state <= ST_TK_ACC;
              end
            end
            tpp_pkg::PH_CRUISE: begin
              if (rel >= cruise_time) begin
                phase_start <= phase_start + cruise_time;
                phase       <= tpp_pkg::PH_DECEL;
              end else begin
                order <= order_sum[POS_WIDTH-1:0];
                fin   <= 1'b0;
                state <= ST_OUT;
              end
            end
            tpp_pkg::PH_DECEL: begin
              if (rel >= decel_time) begin
                phase <= tpp_pkg::PH_END;
              end else begin
                state <= ST_TK_DEC;
              end
            end
            default: begin
              order <= target_position;
              fin   <= 1'b1;
              state <= ST_OUT;
            end
          endcase
        end

        ST_TK_ACC, ST_TK_DEC: begin
          order <= order_sum[POS_WIDTH-1:0];
          fin   <= 1'b0;
          state <= ST_OUT;
        end

        // hand the result to the output register once it is free
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid       <= 1'b1;
            m_tdata        <= order_ext[31:0];
            m_tlast        <= fin;
            previous_order <= order;
            state          <= ST_IDLE;
          end
        end

        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // a unit in progress always has steps left
  a_wait_cnt: assert property (@(posedge clk) disable iff (rst)
    state == ST_WAIT |-> cnt != '0)
    else $error("iteration count ran out while waiting");

  // a result only appears from the output step
  a_out_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT)
    else $error("result raised outside the output step");

  // output step with a free register always delivers
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    state == ST_OUT && !m_tvalid |=> m_tvalid && state == ST_IDLE)
    else $error("free output register not loaded");

  // a zero-distance start ends the move at once
  a_zero_move: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == tpp_pkg::CMD_START && s_tdata[31:0] == 32'd0
    |=> phase == tpp_pkg::PH_END && state == ST_IDLE)
    else $error("zero distance did not end the move");
`endif

endmodule

>>> verif/trapezoid_position_profile_tb.sv
`timescale 1ns / 1ps

module trapezoid_position_profile_tb;

  localparam int FRAC        = tpp_pkg::SQRT_FRAC_DEF;
  localparam int PLAN_CYCLES = 400;    // longest start planning, with margin
  localparam int STALL_LIMIT = 20000;  // cycles with no handshake at all

  typedef struct packed {
    logic [31:0] order;
    logic        fin;
  } result_t;

  // directed rows: either a register set or one item
  typedef enum logic {ROW_REGS, ROW_ITEM} row_kind_t;
  typedef struct {
    row_kind_t   kind;
    logic        cmd;
    logic [31:0] len;      // max_speed on a register row
    logic [31:0] pos;      // acceleration on a register row
    logic [31:0] per;      // deceleration on a register row
    logic        typed;    // expected result written out in the row
    logic [31:0] t_order;
    logic        t_fin;
  } row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = tpp_pkg::REG_MAX_SPEED;
  logic [23:0] cfg_data = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;   // distance, start_position, period
  logic        s_tuser = tpp_pkg::CMD_START;   // command
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;        // position_order
  logic        m_tlast;        // finished

  trapezoid_position_profile dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------
  // profile predictor: own copy of registers and motion state
  // ---------------------------------------------------------------
  longint      spd_reg, acc_reg, dec_reg;
  logic [2:0]  mv_phase;
  logic [31:0] mv_phase_start, mv_t_acc, mv_t_cru, mv_t_dec;
  longint      mv_acc, mv_dec, mv_spd, mv_start_ord, mv_prev_ord, mv_target;

  result_t     order_q[$];     // position orders still owed by the block
  int          errors = 0;
  int          items_sent = 0;
  int          send_idle = 0;  // sender idle chance per cycle, percent
  int          recv_stall = 0; // receiver stall chance, percent

  // low 32 bits, sign extended
  function automatic longint wrap32(longint x);
    logic [31:0] lo;
    lo = x[31:0];
    return {{32{lo[31]}}, lo};
  endfunction

  // floor(sqrt(x) * 2^fb), digit by digit
  function automatic longint unsigned root_fx(longint unsigned x, int fb);
    longint unsigned root, rem, bits, trial;
    int p;
    root = 0;
    rem = 0;
    for (p = 31 + fb; p >= 0; p--) begin
      bits = (p >= fb) ? ((x >> (2 * (p - fb))) & 64'd3) : 64'd0;
      rem = (rem << 2) | bits;
      trial = (root << 2) | 64'd1;
      root = root << 1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = root | 64'd1;
      end
    end
    return root;
  endfunction

  // round(sqrt(num/den)), halves up
  function automatic longint unsigned root_ratio(longint unsigned num, longint unsigned den);
    longint unsigned q;
    q = (64'd4 * num) / den;
    return (root_fx(q, 0) + 64'd1) / 64'd2;
  endfunction

  task automatic plan_move(longint distance);
    longint a, d, v, m, sg, t1, t2, t3, spd, feas, b, q, o1, o2, r, delta;
    longint unsigned s, vs, ds;
    a = acc_reg;
    d = dec_reg;
    v = spd_reg;
    m = distance < 0 ? -distance : distance;
    sg = distance > 0 ? 1 : -1;
    t1 = v / a;
    t2 = 0;
    t3 = v / d;
    spd = v;
    feas = a * t1 * t1 + 2 * v * t3 - d * t3 * t3;
    if (feas > 2 * m) begin
      // cruise speed out of reach: triangle profile
      t3 = root_ratio(2 * a * m, d * (d + a));
      spd = t3 * d;
      b = m - (t3 * t3 * d - (t3 * t3 * d) / 2);
      q = b > 0 ? (2 * b) / a : 0;
      t1 = root_ratio(q, 1);
      t2 = 0;
    end else begin
      o1 = (a * t1 * t1) / 2;
      o2 = m - (d * t3 * t3) / 2;
      t2 = (o2 - o1) / v;
      if (t2 < 0) t2 = 0;
      r = m - t2 * v - o1;
      delta = v * v - 2 * d * r;
      if (delta > 0) begin
        s = root_fx(delta, FRAC);
        vs = longint'(v) << FRAC;
        ds = longint'(d) << FRAC;
        t3 = (s > vs) ? 0 : longint'((vs - s) / ds);
      end
    end
    mv_t_acc = t1[31:0];
    mv_t_cru = t2[31:0];
    mv_t_dec = t3[31:0];
    mv_acc = sg * a;
    mv_dec = sg * d;
    mv_spd = sg * spd;
    mv_phase = tpp_pkg::PH_PRE;
  endtask

  // start item: plan, no result
  task automatic predict_start(logic [31:0] len_bits, logic [31:0] pos_bits, logic [31:0] per);
    longint distance, pos;
    distance = wrap32({32'b0, len_bits});
    pos = wrap32({32'b0, pos_bits});
    mv_phase_start = per;
    mv_start_ord = pos;
    mv_prev_ord = pos;
    mv_target = wrap32(pos + distance);
    if (distance == 0 || spd_reg == 0 || acc_reg == 0 || dec_reg == 0) begin
      mv_t_acc = 0; mv_t_cru = 0; mv_t_dec = 0;
      mv_acc = 0; mv_dec = 0; mv_spd = 0;
      mv_phase = tpp_pkg::PH_END;
    end else begin
      plan_move(distance);
    end
  endtask

  // tick item: walk phases, possibly several per tick
  function automatic result_t predict_tick(logic [31:0] tn);
    logic        have, fin;
    longint      order, rel64;
    logic [31:0] rel;
    result_t     res;
    have = 1'b0;
    fin = 1'b0;
    order = 0;
    if (mv_phase == tpp_pkg::PH_PRE) begin
      if (tn >= mv_phase_start) mv_phase = tpp_pkg::PH_ACCEL;
      else begin
        order = mv_start_ord;
        have = 1'b1;
      end
    end
    if (!have && mv_phase == tpp_pkg::PH_ACCEL) begin
      rel = tn - mv_phase_start;
      rel64 = {32'b0, rel};
      if (rel >= mv_t_acc) begin
        mv_phase_start += mv_t_acc;
        mv_phase = tpp_pkg::PH_CRUISE;
      end else begin
        order = wrap32(mv_acc * rel64 + mv_acc / 2 + mv_prev_ord);
        have = 1'b1;
      end
    end
    if (!have && mv_phase == tpp_pkg::PH_CRUISE) begin
      rel = tn - mv_phase_start;
      if (rel >= mv_t_cru) begin
        mv_phase_start += mv_t_cru;
        mv_phase = tpp_pkg::PH_DECEL;
      end else begin
        order = wrap32(mv_spd + mv_prev_ord);
        have = 1'b1;
      end
    end
    if (!have && mv_phase == tpp_pkg::PH_DECEL) begin
      rel = tn - mv_phase_start;
      rel64 = {32'b0, rel};
      if (rel >= mv_t_dec) mv_phase = tpp_pkg::PH_END;
      else begin
        order = wrap32(-(mv_dec * rel64) - mv_dec / 2 + mv_spd + mv_prev_ord);
        have = 1'b1;
      end
    end
    // end phase and any unused phase code
    if (!have) begin
      order = mv_target;
      fin = 1'b1;
    end
    mv_prev_ord = order;
    res.order = order[31:0];
    res.fin = fin;
    return res;
  endfunction

  // ---------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------
  task automatic send_item(logic cmd, logic [31:0] len, logic [31:0] pos, logic [31:0] per,
                           logic typed = 1'b0, result_t t_res = '0);
    result_t res;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= cmd;
    s_tdata <= {per, pos, len};
    do @(posedge clk); while (!s_tready);
    items_sent++;
    if (cmd == tpp_pkg::CMD_START) predict_start(len, pos, per);
    else begin
      res = predict_tick(per);
      order_q.push_back(typed ? t_res : res);
    end
  endtask

  // drain all results, then let any planning still running finish
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (order_q.size() != 0) @(posedge clk);
    repeat (PLAN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(logic [23:0] v, logic [15:0] a, logic [15:0] d);
    logic [1:0]  idx [3];
    logic [23:0] val [3];
    idx = '{tpp_pkg::REG_MAX_SPEED, tpp_pkg::REG_ACCEL, tpp_pkg::REG_DECEL};
    val = '{v, {8'b0, a}, {8'b0, d}};
    wait_idle();
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data <= val[i];
      do @(posedge clk); while (!cfg_ready);
      case (idx[i])
        tpp_pkg::REG_MAX_SPEED: spd_reg = val[i];
        tpp_pkg::REG_ACCEL:     acc_reg = val[i][15:0];
        default:                dec_reg = val[i][15:0];
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // receiver back-pressure
  always @(posedge clk) m_tready <= ($urandom_range(99) >= recv_stall);

  // ---------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------
  task automatic report(string what, logic [31:0] exp_v, logic [31:0] got_v);
    errors++;
    $display("%0t mismatch %s: expected %h got %h", $time, what, exp_v, got_v);
  endtask

  always @(posedge clk) begin
    result_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (order_q.size() == 0) report("unexpected result", 32'h0, m_tdata);
      else begin
        e = order_q.pop_front();
        if (m_tdata !== e.order) report("position_order", e.order, m_tdata);
        if (m_tlast !== e.fin) report("finished", {31'b0, e.fin}, {31'b0, m_tlast});
      end
    end
  end

  // watchdog: cycles with no handshake on any channel
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end else quiet_cycles <= quiet_cycles + 1;
  end

  // ---------------------------------------------------------------
  // random move: start, then ticks sweeping through the profile
  // ---------------------------------------------------------------
  task automatic random_regs();
    logic [23:0] v;
    logic [15:0] a, d;
    case ($urandom_range(9))
      0: v = '0;
      1: v = 24'hFFFFFF;
      2: v = 24'($urandom);
      default: v = 24'($urandom_range(1, 3000));
    endcase
    case ($urandom_range(9))
      0: a = '0;
      1: a = 16'hFFFF;
      2: a = 16'd1;
      3: a = 16'($urandom);
      default: a = 16'($urandom_range(1, 300));
    endcase
    case ($urandom_range(9))
      0: d = '0;
      1: d = 16'hFFFF;
      2: d = 16'd1;
      3: d = 16'($urandom);
      default: d = 16'($urandom_range(1, 300));
    endcase
    set_regs(v, a, d);
  endtask

  task automatic random_move();
    logic [31:0]     len, pos, p0, per;
    longint unsigned span, stride;
    int              n;
    case ($urandom_range(19))
      0: len = '0;
      1, 2: len = $urandom;
      default: begin
        len = $urandom_range(1, 200000);
        if ($urandom_range(1)) len = -len;
      end
    endcase
    pos = $urandom;
    p0 = ($urandom_range(9) == 0) ? 32'hFFFFFFFF - $urandom_range(0, 40) : $urandom;
    send_item(tpp_pkg::CMD_START, len, pos, p0);
    span = longint'(mv_t_acc) + mv_t_cru + mv_t_dec;
    stride = span / 16 + 1;
    per = p0 - $urandom_range(0, 2);
    n = $urandom_range(12, 24);
    for (int i = 0; i < n; i++) begin
      send_item(tpp_pkg::CMD_TICK, $urandom, $urandom, per);
      if ($urandom_range(9) == 0) per = per;   // same period again
      else per = per + 32'($urandom_range(1, int'(stride > 64'd1000000 ? 2000000 : 2 * stride)));
    end
  endtask

  // ---------------------------------------------------------------
  // directed rows
  // ---------------------------------------------------------------
  row_t rows[$] = '{
    // no move yet: target zero, finished
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'h0, 1'b1, 32'h0, 1'b1},
    '{ROW_REGS, tpp_pkg::CMD_START, 32'd100, 32'd10, 32'd10, 1'b0, 32'h0, 1'b0},
    // zero distance ends at once
    '{ROW_ITEM, tpp_pkg::CMD_START, 32'h0, 32'h7FFFFFFF, 32'd5, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd6, 1'b1, 32'h7FFFFFFF, 1'b1},
    // tick ahead of the start period holds the start position
    '{ROW_ITEM, tpp_pkg::CMD_START, 32'd1000, 32'hFFFFFFFB, 32'd100, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd99, 1'b1, 32'hFFFFFFFB, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd100, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd105, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd115, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd300, 1'b0, 32'h0, 1'b0},
    // most negative distance, period wraps past zero
    '{ROW_ITEM, tpp_pkg::CMD_START, 32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFE, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    // all registers at their top
    '{ROW_REGS, tpp_pkg::CMD_START, 32'hFFFFFF, 32'hFFFF, 32'hFFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_START, 32'h7FFFFFFF, 32'h0, 32'h0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd1, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd300, 1'b0, 32'h0, 1'b0},
    // zero speed ends at once
    '{ROW_REGS, tpp_pkg::CMD_START, 32'h0, 32'd1, 32'd1, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_START, 32'd10, 32'd20, 32'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd1, 1'b1, 32'd30, 1'b1},
    // speed out of reach: triangle profile
    '{ROW_REGS, tpp_pkg::CMD_START, 32'hFFFFFF, 32'd1, 32'hFFFF, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_START, 32'd12345, 32'd0, 32'd0, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd10, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd150, 1'b0, 32'h0, 1'b0},
    '{ROW_ITEM, tpp_pkg::CMD_TICK,  32'h0, 32'h0, 32'd400, 1'b0, 32'h0, 1'b0}
  };

  // ---------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------
  initial begin
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 83, 0, 10};
    recv_pct = '{0, 0, 83, 10};
    spd_reg = 0; acc_reg = 0; dec_reg = 0;
    mv_phase = tpp_pkg::PH_END;
    mv_phase_start = 0; mv_t_acc = 0; mv_t_cru = 0; mv_t_dec = 0;
    mv_acc = 0; mv_dec = 0; mv_spd = 0;
    mv_start_ord = 0; mv_prev_ord = 0; mv_target = 0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REGS)
        set_regs(rows[i].len[23:0], rows[i].pos[15:0], rows[i].per[15:0]);
      else
        send_item(rows[i].cmd, rows[i].len, rows[i].pos, rows[i].per,
                  rows[i].typed, '{rows[i].t_order, rows[i].t_fin});
    end

    // random part in four idling phases; each phase starts from a drained block
    for (int ph = 0; ph < 4; ph++) begin
      set_regs(24'd500, 16'd20, 16'd30);
      send_idle = send_pct[ph];
      recv_stall = recv_pct[ph];
      while (items_sent < 25 + 450 * (ph + 1)) begin
        if ($urandom_range(7) == 0) random_regs();
        if ($urandom_range(6) == 0)
          send_item($urandom_range(1), $urandom, $urandom, $urandom);   // noise
        else
          random_move();
      end
    end

    send_idle = 0;
    recv_stall = 0;
    wait_idle();
    if (order_q.size() != 0) report("results never delivered", order_q.size(), 32'h0);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
